@@ sv/v3a_pkg.sv @@
// shared types, operation codes and saturation helper for the vector alu
package v3a_pkg;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_DIFF  = 4'd1,
		OP_SCALE = 4'd2,
		OP_DOT   = 4'd3,
		OP_CROSS = 4'd4,
		OP_MAG   = 4'd5,
		OP_NORM  = 4'd6,
		OP_DIST  = 4'd7,
		OP_EQUAL = 4'd8
	} op_t;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = 32'sh7fffffff;
	localparam q_t Q_MIN = 32'sh80000000;

	localparam int MUL_N         = 6;
	localparam int SQ_STEPS      = 32;
	localparam int DIV_STEPS     = 17;
	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic [3:0] operation;
		q_t         u_x;
		q_t         u_y;
		q_t         u_z;
		q_t         v_x;
		q_t         v_y;
		q_t         v_z;
		q_t         scale;
	} in_word_t;

	typedef struct packed {
		q_t   res_x;
		q_t   res_y;
		q_t   res_z;
		q_t   res_scalar;
		logic is_equal;
		logic overflow;
	} out_word_t;

	// per-item state that rides along the execution pipeline
	typedef struct packed {
		logic [3:0]       op;
		q_t [2:0]         vec;
		q_t               scal;
		logic             eq;
		logic             ovf;
		logic             big;
		logic [2:0]       neg;
		logic [2:0][31:0] uabs;
	} carry_t;

	typedef struct packed {
		carry_t          c;
		q_t [MUL_N-1:0]  mul_a;
		q_t [MUL_N-1:0]  mul_b;
	} mid_word_t;

	typedef struct packed {
		logic ovf;
		q_t   val;
	} sat_t;

	function automatic sat_t sat_q(input logic signed [49:0] v);
		sat_t r;
		if (v > 50'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = Q_MAX;
		end else if (v < -50'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = Q_MIN;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ sv/v3a_fifo.sv @@
// small register queue used between front, back and the result side
module v3a_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ sv/v3a_front.sv @@
// front end: decodes the operation, does the cheap ops and picks multiplier operands
module v3a_front (
	input  v3a_pkg::in_word_t  item,
	output v3a_pkg::mid_word_t word
);
	import v3a_pkg::*;

	q_t                 u [3];
	q_t                 v [3];
	logic signed [32:0] s [3];
	logic signed [32:0] d [3];
	sat_t               ss [3];
	sat_t               sd [3];

	always_comb begin
		u[0] = item.u_x;
		u[1] = item.u_y;
		u[2] = item.u_z;
		v[0] = item.v_x;
		v[1] = item.v_y;
		v[2] = item.v_z;
		for (int i = 0; i < 3; i++) begin
			s[i]  = 33'(u[i]) + 33'(v[i]);
			d[i]  = 33'(u[i]) - 33'(v[i]);
			ss[i] = sat_q(50'(s[i]));
			sd[i] = sat_q(50'(d[i]));
		end
	end

	always_comb begin
		word      = '0;
		word.c.op = item.operation;
		for (int i = 0; i < 3; i++) begin
			word.c.neg[i]  = u[i][31];
			word.c.uabs[i] = u[i][31] ? 32'(-u[i]) : 32'(u[i]);
		end
		unique case (item.operation) inside
			OP_ADD: begin
				for (int i = 0; i < 3; i++) begin
					word.c.vec[i] = ss[i].val;
				end
				word.c.ovf = ss[0].ovf | ss[1].ovf | ss[2].ovf;
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					word.c.vec[i] = sd[i].val;
				end
				word.c.ovf = sd[0].ovf | sd[1].ovf | sd[2].ovf;
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					word.mul_a[i] = u[i];
					word.mul_b[i] = item.scale;
				end
			end
			OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					word.mul_a[i] = u[i];
					word.mul_b[i] = v[i];
				end
			end
			OP_CROSS: begin
				// pairs: x from y,z  y from z,x  z from x,y
				word.mul_a[0] = u[1];
				word.mul_b[0] = v[2];
				word.mul_a[1] = u[2];
				word.mul_b[1] = v[1];
				word.mul_a[2] = u[2];
				word.mul_b[2] = v[0];
				word.mul_a[3] = u[0];
				word.mul_b[3] = v[2];
				word.mul_a[4] = u[0];
				word.mul_b[4] = v[1];
				word.mul_a[5] = u[1];
				word.mul_b[5] = v[0];
			end
			OP_MAG, OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					word.mul_a[i] = u[i];
					word.mul_b[i] = u[i];
				end
			end
			OP_DIST: begin
				for (int i = 0; i < 3; i++) begin
					word.mul_a[i] = d[i][31:0];
					word.mul_b[i] = d[i][31:0];
					if (d[i] > 33'sd2147483647 || d[i] <= -33'sd2147483648) begin
						word.c.big = 1'b1;
					end
				end
			end
			OP_EQUAL: begin
				word.c.eq = (u[0] == v[0]) && (u[1] == v[1]) && (u[2] == v[2]);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/v3a_back.sv @@
// back end: multiply, round, root and divide pipeline with one shared advance
module v3a_back (
	input  logic               clk,
	input  logic               arst_n,
	input  v3a_pkg::mid_word_t word,
	input  logic               word_empty,
	output logic               word_pop,
	output v3a_pkg::out_word_t res,
	output logic               res_push,
	input  logic               res_full
);
	import v3a_pkg::*;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_t;

	typedef struct packed {
		logic [2:0][49:0] rem;
		logic [2:0][16:0] quo;
		logic [33:0]      dvs;
	} dv_t;

	function automatic sq_t sq_step(input sq_t x);
		logic [35:0] r2;
		logic [35:0] tr;
		sq_t         y;
		r2    = {x.rem[33:0], x.rad[63:62]};
		tr    = {2'b00, x.root, 2'b01};
		y.rad = {x.rad[61:0], 2'b00};
		if (r2 >= tr) begin
			y.rem  = r2 - tr;
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem  = r2;
			y.root = {x.root[30:0], 1'b0};
		end
		return y;
	endfunction

	logic adv;

	// products
	logic               v_s1;
	carry_t             c_s1;
	logic signed [63:0] prod_s1 [MUL_N];

	// rounded sums
	logic               v_s2;
	carry_t             c_s2;
	logic signed [49:0] rvec_s2 [3];
	logic signed [49:0] rdot_s2;
	logic [63:0]        rad_s2;

	logic signed [63:0] tsc [3];
	logic signed [64:0] tcr [3];
	logic signed [65:0] tdot;
	logic [63:0]        rad_c;

	// root steps
	logic   sq_v_s [SQ_STEPS];
	carry_t sq_c_s [SQ_STEPS];
	sq_t    sq_s   [SQ_STEPS];
	carry_t c3;
	sq_t    sq0;
	sat_t   sv [3];
	sat_t   sdot;

	// root rounding and divider set-up
	logic        v_sr;
	carry_t      c_sr;
	dv_t         dv_sr;
	logic [32:0] m;
	carry_t      c_rn;
	dv_t         dv0;

	// divider steps
	logic   dv_v_s [DIV_STEPS];
	carry_t dv_c_s [DIV_STEPS];
	dv_t    dv_s   [DIV_STEPS];

	carry_t cf;

	assign adv      = !dv_v_s[DIV_STEPS-1] || !res_full;
	assign word_pop = adv && !word_empty;
	assign res_push = dv_v_s[DIV_STEPS-1] && !res_full;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !word_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= word.c;
			for (int k = 0; k < MUL_N; k++) begin
				prod_s1[k] <= $signed(word.mul_a[k]) * $signed(word.mul_b[k]);
			end
		end
	end

	// stage 2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tsc[i] = prod_s1[i] + 64'sd32768;
			tcr[i] = 65'(prod_s1[2*i]) - 65'(prod_s1[2*i+1]) + 65'sd32768;
		end
		tdot  = 66'(prod_s1[0]) + 66'(prod_s1[1]) + 66'(prod_s1[2]) + 66'sd32768;
		rad_c = 64'(prod_s1[0]) + 64'(prod_s1[1]) + 64'(prod_s1[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2 <= c_s1;
			for (int i = 0; i < 3; i++) begin
				rvec_s2[i] <= (c_s1.op == OP_CROSS) ? 50'(tcr[i] >>> 16) : 50'(tsc[i] >>> 16);
			end
			rdot_s2 <= 50'(tdot >>> 16);
			rad_s2  <= rad_c;
		end
	end

	// saturation of products, root set-up
	always_comb begin
		c3 = c_s2;
		for (int i = 0; i < 3; i++) begin
			sv[i] = sat_q(rvec_s2[i]);
		end
		sdot = sat_q(rdot_s2);
		unique case (c_s2.op) inside
			OP_SCALE, OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					c3.vec[i] = sv[i].val;
				end
				c3.ovf = sv[0].ovf | sv[1].ovf | sv[2].ovf;
			end
			OP_DOT: begin
				c3.scal = sdot.val;
				c3.ovf  = sdot.ovf;
			end
			default: begin
			end
		endcase
		sq0.rem  = '0;
		sq0.root = '0;
		sq0.rad  = rad_s2;
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		sq_t    sin;
		carry_t cin;
		logic   vin;

		if (j == 0) begin : g_first
			always_comb begin
				sin = sq0;
				cin = c3;
				vin = v_s2;
			end
		end else begin : g_next
			always_comb begin
				sin = sq_s[j-1];
				cin = sq_c_s[j-1];
				vin = sq_v_s[j-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j] <= 1'b0;
			end else if (adv) begin
				sq_v_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[j]   <= sq_step(sin);
				sq_c_s[j] <= cin;
			end
		end
	end

	// round the root, finish magnitude and distance, set up the quotients
	always_comb begin
		m    = {1'b0, sq_s[SQ_STEPS-1].root}
			+ 33'(sq_s[SQ_STEPS-1].rem > 36'(sq_s[SQ_STEPS-1].root));
		c_rn = sq_c_s[SQ_STEPS-1];
		unique case (c_rn.op) inside
			OP_MAG, OP_DIST: begin
				if (c_rn.op == OP_DIST && c_rn.big) begin
					c_rn.scal = Q_MAX;
					c_rn.ovf  = 1'b1;
				end else if (m > 33'd2147483647) begin
					c_rn.scal = Q_MAX;
					c_rn.ovf  = 1'b1;
				end else begin
					c_rn.scal = m[31:0];
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			dv0.rem[i] = 50'({c_rn.uabs[i], 17'b0}) + 50'(m);
			dv0.quo[i] = '0;
		end
		dv0.dvs = {m, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else if (adv) begin
			v_sr <= sq_v_s[SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_sr  <= c_rn;
			dv_sr <= dv0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		localparam int SH = DIV_STEPS - 1 - k;
		dv_t         din;
		dv_t         dout;
		carry_t      cin;
		logic        vin;
		logic [50:0] sh;

		if (k == 0) begin : g_first
			always_comb begin
				din = dv_sr;
				cin = c_sr;
				vin = v_sr;
			end
		end else begin : g_next
			always_comb begin
				din = dv_s[k-1];
				cin = dv_c_s[k-1];
				vin = dv_v_s[k-1];
			end
		end

		always_comb begin
			sh       = 51'(din.dvs) << SH;
			dout.dvs = din.dvs;
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, din.rem[i]} >= sh) begin
					dout.rem[i] = din.rem[i] - sh[49:0];
					dout.quo[i] = {din.quo[i][15:0], 1'b1};
				end else begin
					dout.rem[i] = din.rem[i];
					dout.quo[i] = {din.quo[i][15:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k]   <= dout;
				dv_c_s[k] <= cin;
			end
		end
	end

	// result word
	always_comb begin
		cf = dv_c_s[DIV_STEPS-1];
		if (cf.op == OP_NORM && dv_s[DIV_STEPS-1].dvs != '0) begin
			for (int i = 0; i < 3; i++) begin
				cf.vec[i] = cf.neg[i] ? -{15'b0, dv_s[DIV_STEPS-1].quo[i]}
					: {15'b0, dv_s[DIV_STEPS-1].quo[i]};
			end
		end
		res.res_x      = cf.vec[0];
		res.res_y      = cf.vec[1];
		res.res_z      = cf.vec[2];
		res.res_scalar = cf.scal;
		res.is_equal   = cf.eq;
		res.overflow   = cf.ovf;
	end

endmodule

@@ sv/vector3_fixed_point_alu_unit.sv @@
// top level of the three-component q16.16 vector alu
//
// queue-style ports on both sides: a word goes in on push while full is low and comes out on
// pop while empty is low. every word, whatever its operation, takes the same path: a front
// decoder (add, diff, equal and operand selection), a small queue, then a 52-stage execution
// pipeline (one stage of six 32x32 multipliers, one stage of rounding sums, 32 stages of a
// bit-per-stage square root, one root rounding stage, 17 stages of three parallel restoring
// dividers for normalize) and a result queue. one word is taken every cycle while results are
// drained. a stall on the result side freezes the whole execution pipeline at once, and the
// middle queue keeps the input side taking words until it fills. results saturate to q16.16
// and raise overflow; normalize of a zero vector returns the null vector.
module vector3_fixed_point_alu_unit #(
	parameter int MID_DEPTH = v3a_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = v3a_pkg::OUT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  v3a_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output v3a_pkg::out_word_t result
);
	import v3a_pkg::*;

	mid_word_t front_word;
	mid_word_t mid_word;
	logic      mid_empty;
	logic      mid_pop;
	out_word_t back_word;
	logic      back_push;
	logic      out_full;

	// decode and cheap ops
	v3a_front u_front (
		.item (item),
		.word (front_word)
	);

	// lets the front keep taking words while the pipeline is held
	v3a_fifo #(
		.W     ($bits(mid_word_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_word),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_word),
		.empty  (mid_empty)
	);

	// multiply, root and divide pipeline
	v3a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (mid_word),
		.word_empty (mid_empty),
		.word_pop   (mid_pop),
		.res        (back_word),
		.res_push   (back_push),
		.res_full   (out_full)
	);

	// result queue
	v3a_fifo #(
		.W     ($bits(out_word_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_push),
		.wdata  (back_word),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the three-component q16.16 vector alu
module tb;

	import v3a_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_word_t  item;
	logic      empty;
	logic      pop;
	out_word_t result;

	vector3_fixed_point_alu_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// clock, period 2
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	out_word_t expected_words[$];
	int        error_count;
	int        idle_cycles;
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        hold_recv;
	int        hold_len;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;

	// ---------------------------------------------------------------------------------------
	// predictor: exact wide arithmetic, then a single rounding and saturation
	// ---------------------------------------------------------------------------------------

	// floor division by 2^16 via arithmetic shift
	function automatic logic signed [127:0] fl16(input logic signed [127:0] p);
		return p >>> 16;
	endfunction

	function automatic q_t clamp_q(input logic signed [127:0] v, inout bit ovf);
		if (v > 128'sd2147483647) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		if (v < -128'sd2147483648) begin
			ovf = 1'b1;
			return Q_MIN;
		end
		return q_t'(v[31:0]);
	endfunction

	// integer square root rounded to nearest
	function automatic logic [63:0] root_nearest(input logic [127:0] s);
		logic [127:0] r;
		logic [127:0] b;
		logic [127:0] rem;
		r = 0;
		b = 128'd1 << 126;
		rem = s;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s - r * r > r)
			r = r + 1;
		return r[63:0];
	endfunction

	function automatic logic [127:0] square_sum(input logic signed [127:0] a0,
			input logic signed [127:0] a1, input logic signed [127:0] a2);
		return a0 * a0 + a1 * a1 + a2 * a2;
	endfunction

	function automatic out_word_t predict_alu(input in_word_t w);
		out_word_t r;
		logic signed [127:0] u[3];
		logic signed [127:0] v[3];
		logic signed [127:0] d[3];
		logic signed [127:0] sc;
		logic signed [127:0] acc;
		logic [127:0] m;
		logic [127:0] a;
		logic [127:0] q;
		bit ovf;
		bit big;
		r = '0;
		ovf = 1'b0;
		big = 1'b0;
		u[0] = w.u_x; u[1] = w.u_y; u[2] = w.u_z;
		v[0] = w.v_x; v[1] = w.v_y; v[2] = w.v_z;
		sc = w.scale;
		case (w.operation)
			OP_ADD: begin
				r.res_x = clamp_q(u[0] + v[0], ovf);
				r.res_y = clamp_q(u[1] + v[1], ovf);
				r.res_z = clamp_q(u[2] + v[2], ovf);
			end
			OP_DIFF: begin
				r.res_x = clamp_q(u[0] - v[0], ovf);
				r.res_y = clamp_q(u[1] - v[1], ovf);
				r.res_z = clamp_q(u[2] - v[2], ovf);
			end
			OP_SCALE: begin
				r.res_x = clamp_q(fl16(u[0] * sc + 32768), ovf);
				r.res_y = clamp_q(fl16(u[1] * sc + 32768), ovf);
				r.res_z = clamp_q(fl16(u[2] * sc + 32768), ovf);
			end
			OP_DOT: begin
				acc = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
				r.res_scalar = clamp_q(fl16(acc + 32768), ovf);
			end
			OP_CROSS: begin
				r.res_x = clamp_q(fl16(u[1] * v[2] - u[2] * v[1] + 32768), ovf);
				r.res_y = clamp_q(fl16(u[2] * v[0] - u[0] * v[2] + 32768), ovf);
				r.res_z = clamp_q(fl16(u[0] * v[1] - u[1] * v[0] + 32768), ovf);
			end
			OP_MAG: begin
				m = root_nearest(square_sum(u[0], u[1], u[2]));
				r.res_scalar = clamp_q(m, ovf);
			end
			OP_NORM: begin
				m = root_nearest(square_sum(u[0], u[1], u[2]));
				if (m != 0) begin
					for (int i = 0; i < 3; i++) begin
						a = (u[i] < 0 ? -u[i] : u[i]) * 65536;
						q = (2 * a + m) / (2 * m);
						d[i] = u[i] < 0 ? -$signed(q) : $signed(q);
					end
					r.res_x = q_t'(d[0][31:0]);
					r.res_y = q_t'(d[1][31:0]);
					r.res_z = q_t'(d[2][31:0]);
				end
			end
			OP_DIST: begin
				for (int i = 0; i < 3; i++) begin
					d[i] = u[i] - v[i];
					if (d[i] <= -128'sd2147483648 || d[i] > 128'sd2147483647)
						big = 1'b1;
				end
				if (big) begin
					ovf = 1'b1;
					r.res_scalar = Q_MAX;
				end else begin
					m = root_nearest(square_sum(d[0], d[1], d[2]));
					r.res_scalar = clamp_q(m, ovf);
				end
			end
			OP_EQUAL: begin
				r.is_equal = (w.u_x == w.v_x) && (w.u_y == w.v_y) && (w.u_z == w.v_z);
			end
			default: begin
			end
		endcase
		r.overflow = ovf;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------------------------

	// send one word, idling at random beforehand; push stays high across back-to-back words
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_words.push_back(predict_alu(w));
	endtask

	// operand values biased toward corner cases
	function automatic q_t pick_q();
		case ($urandom_range(9, 0))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return q_t'(0);
			3: return q_t'($urandom_range(131072, 0)) - q_t'(65536);
			4, 5: return q_t'($urandom_range(8388607, 0)) - q_t'(4194304);
			default: return q_t'($urandom);
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.operation = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 9))
			: 4'($urandom_range(8, 0));
		w.u_x = pick_q(); w.u_y = pick_q(); w.u_z = pick_q();
		w.v_x = pick_q(); w.v_y = pick_q(); w.v_z = pick_q();
		w.scale = pick_q();
		// equality needs matching operands often enough to matter
		if (w.operation == OP_EQUAL && $urandom_range(1, 0) == 1) begin
			w.v_x = w.u_x; w.v_y = w.u_y;
			if ($urandom_range(1, 0) == 1)
				w.v_z = w.u_z;
		end
		return w;
	endfunction

	function automatic in_word_t make_word(input logic [3:0] op, input q_t ux, input q_t uy,
			input q_t uz, input q_t vx, input q_t vy, input q_t vz, input q_t s);
		in_word_t w;
		w.operation = op;
		w.u_x = ux; w.u_y = uy; w.u_z = uz;
		w.v_x = vx; w.v_y = vy; w.v_z = vz;
		w.scale = s;
		return w;
	endfunction

	// stop offering words, then wait for every expected word to come out
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------------------

	// each operation on ordinary operands and at the extremes of range
	task automatic test_directed();
		q_t one;
		one = q_t'(65536);
		send_word(make_word(OP_ADD, one, -one, 0, one, one, 0, 0));
		send_word(make_word(OP_ADD, Q_MAX, Q_MIN, 1, 1, -1, -1, 0));
		send_word(make_word(OP_DIFF, Q_MIN, Q_MAX, 0, 1, -1, Q_MIN, 0));
		send_word(make_word(OP_SCALE, one, -one, 3, 0, 0, 0, one + one));
		send_word(make_word(OP_SCALE, Q_MAX, Q_MIN, Q_MIN, 0, 0, 0, Q_MIN));
		// rounding ties in a scale product
		send_word(make_word(OP_SCALE, 1, -1, 3, 0, 0, 0, 32768));
		send_word(make_word(OP_DOT, one, one, one, one, one, one, 0));
		send_word(make_word(OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0));
		send_word(make_word(OP_CROSS, one, 0, 0, 0, one, 0, 0));
		send_word(make_word(OP_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
		send_word(make_word(OP_MAG, 3 * one, 4 * one, 0, 0, 0, 0, 0));
		send_word(make_word(OP_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
		send_word(make_word(OP_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0));
		// zero vector normalises to the null vector
		send_word(make_word(OP_NORM, 0, 0, 0, 5, 5, 5, 0));
		send_word(make_word(OP_NORM, Q_MIN, Q_MAX, 1, 0, 0, 0, 0));
		send_word(make_word(OP_DIST, one, one, one, 0, 0, 0, 0));
		// difference outside range forces saturated distance
		send_word(make_word(OP_DIST, Q_MAX, 0, 0, Q_MIN, 0, 0, 0));
		send_word(make_word(OP_DIST, Q_MIN, 0, 0, 0, 0, 0, 0));
		send_word(make_word(OP_EQUAL, 7, Q_MIN, Q_MAX, 7, Q_MIN, Q_MAX, 0));
		send_word(make_word(OP_EQUAL, 7, Q_MIN, Q_MAX, 7, Q_MIN, Q_MIN, 0));
		// unused operation codes
		send_word(make_word(4'd9, one, one, one, one, one, one, one));
		send_word(make_word(4'd15, -1, -1, -1, -1, -1, -1, -1));
		send_word(make_word(OP_ADD, -1, -1, -1, -1, -1, -1, -1));
		wait_drained();
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n; i++)
			send_word(random_word());
		wait_drained();
	endtask

	// receiver stalls for a long stretch while words keep coming, so full must rise
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 200;
		hold_recv = 1'b1;
		for (int i = 0; i < 120; i++)
			send_word(random_word());
		wait_drained();
	endtask

	// ---------------------------------------------------------------------------------------
	// result side: random pops, long hold on request, checking against the expected queue
	// ---------------------------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_recv) begin
			pop <= 1'b0;
			if (hold_len == 0)
				hold_recv <= 1'b0;
			else
				hold_len <= hold_len - 1;
		end else begin
			pop <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				exp_w = expected_words.pop_front();
				if (result.res_x !== exp_w.res_x) begin
					$error("res_x expected %0d got %0d", exp_w.res_x, result.res_x);
					error_count++;
				end
				if (result.res_y !== exp_w.res_y) begin
					$error("res_y expected %0d got %0d", exp_w.res_y, result.res_y);
					error_count++;
				end
				if (result.res_z !== exp_w.res_z) begin
					$error("res_z expected %0d got %0d", exp_w.res_z, result.res_z);
					error_count++;
				end
				if (result.res_scalar !== exp_w.res_scalar) begin
					$error("res_scalar expected %0d got %0d", exp_w.res_scalar,
						result.res_scalar);
					error_count++;
				end
				if (result.is_equal !== exp_w.is_equal) begin
					$error("is_equal expected %0b got %0b", exp_w.is_equal, result.is_equal);
					error_count++;
				end
				if (result.overflow !== exp_w.overflow) begin
					$error("overflow expected %0b got %0b", exp_w.overflow, result.overflow);
					error_count++;
				end
			end
		end
	end

	// watchdog: cycles without any word moving on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_recv = 1'b0;
		hold_len = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, 27, 72);
		test_random(250, 72, 27);
		test_random(150, 0, 0);
		test_backpressure();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ vector3_fixed_point_alu_unit.f @@
sv/v3a_pkg.sv
sv/v3a_fifo.sv
sv/v3a_front.sv
sv/v3a_back.sv
sv/vector3_fixed_point_alu_unit.sv
dv/tb.sv
